// File: src/hjc_pkg.sv
// Shared constants and types for the headset jack classifier.
package hjc_pkg;

  localparam int DEF_SAMPLE_BITS = 10;
  localparam int AUTO_FLOOR_RST  = 100;
  localparam int QUEUE_DEPTH     = 4;

  typedef struct packed {
    logic fast_poll;
    logic button_bit;
    logic microphone_bit;
    logic headphone_bit;
  } hjc_flags_t;

  typedef struct packed {
    logic restart;
    logic manual_zero;
  } hjc_ctrl_t;

endpackage

// File: src/hjc_front.sv
// Front stage: accepts a request and precomputes the state-independent products.
module hjc_front
  import hjc_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int ITEM_W      = 4 * DEF_SAMPLE_BITS + 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   conv_error,
  output logic                   item_valid,
  input  logic                   item_ready,
  output logic [ITEM_W-1:0]      item
);

  localparam int XW     = SAMPLE_BITS + 5;
  localparam int SHIFT  = SAMPLE_BITS + 10;
  localparam int PW     = 2 * SAMPLE_BITS + 11;
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) / 21) + 1;

  logic [XW-1:0]          x20;
  logic [XW-1:0]          x20m2;
  logic [XW-1:0]          x20p1;
  logic                   gt2;
  logic [PW-1:0]          prod;
  logic [SAMPLE_BITS-1:0] quot;

  always_comb begin
    x20   = {1'b0, sample, 4'b0000} + {3'b000, sample, 2'b00};
    x20m2 = x20 - XW'(40);
    x20p1 = x20 + XW'(20);
    gt2   = sample > SAMPLE_BITS'(2);
    prod  = PW'(x20) * PW'(RECIP);
    quot  = prod[SHIFT +: SAMPLE_BITS];
  end

  assign in_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      item <= {conv_error, gt2, sample, quot, x20m2, x20p1};
    end
  end

endmodule

// File: src/hjc_fifo.sv
// Small request queue between the front and back stages.
module hjc_fifo
  import hjc_pkg::*;
#(
  parameter int WIDTH = 4 * DEF_SAMPLE_BITS + 12,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             push;
  logic             pop;

  assign in_ready  = count != (AW+1)'(DEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW+1)'(1);
      end
    end
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

endmodule

// File: src/hjc_back.sv
// Back stage: calibration state, jack classification and output register.
module hjc_back
  import hjc_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int ITEM_W      = 4 * DEF_SAMPLE_BITS + 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  hjc_ctrl_t              ctrl,
  input  logic [SAMPLE_BITS-1:0] restart_level,
  input  logic [SAMPLE_BITS-1:0] floor_rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  logic [ITEM_W-1:0]      item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   report_valid,
  output hjc_flags_t             flags,
  output logic [SAMPLE_BITS-1:0] level_now
);

  localparam int XW = SAMPLE_BITS + 5;
  localparam logic [1:0] PRES_NONE      = 2'd0;
  localparam logic [1:0] PRES_HEADPHONE = 2'd1;
  localparam logic [1:0] PRES_HEADSET   = 2'd2;

  logic [SAMPLE_BITS-1:0] cal_level, cal_level_next;
  logic [SAMPLE_BITS-1:0] cand_level, cand_level_next;
  logic [1:0]             run_count, run_count_next;
  logic [1:0]             presence, presence_next;

  logic                   err;
  logic                   gt2;
  logic [SAMPLE_BITS-1:0] val;
  logic [SAMPLE_BITS-1:0] quot;
  logic [XW-1:0]          x20m2;
  logic [XW-1:0]          x20p1;
  logic [XW-1:0]          cal21;
  logic [XW-1:0]          cand21;
  logic                   cal_hi;
  logic                   take;
  logic                   rv_next;
  hjc_flags_t             flags_next;
  logic                   fire;

  assign {err, gt2, val, quot, x20m2, x20p1} = item;
  assign item_ready = !out_valid || out_ready;
  assign fire       = item_valid && item_ready;

  always_comb begin
    cal21  = {1'b0, cal_level, 4'b0000} + {3'b000, cal_level, 2'b00} + XW'(cal_level);
    cand21 = {1'b0, cand_level, 4'b0000} + {3'b000, cand_level, 2'b00} + XW'(cand_level);
    cal_hi = gt2 && (cal21 < x20m2);
    take   = (run_count == 2'd0) || (x20p1 <= cand21);

    cal_level_next  = cal_level;
    cand_level_next = cand_level;
    run_count_next  = run_count;
    presence_next   = presence;
    rv_next         = 1'b0;
    flags_next      = '0;
    flags_next.fast_poll = presence != PRES_NONE;

    if (!err) begin
      rv_next = 1'b1;
      if (ctrl.manual_zero) begin
        if (cal_hi) begin
          if (take) begin
            cand_level_next = quot;
          end
          if (run_count == 2'd3) begin
            cal_level_next = cand_level_next;
            run_count_next = 2'd0;
          end else begin
            run_count_next = run_count + 2'd1;
          end
        end else begin
          run_count_next = 2'd0;
        end
      end

      if (val < (cal_level_next >> 1)) begin
        presence_next        = PRES_NONE;
        flags_next.fast_poll = 1'b0;
      end else if (val < cal_level_next) begin
        flags_next.headphone_bit = 1'b1;
        if (presence == PRES_NONE) begin
          presence_next = PRES_HEADPHONE;
        end else if (presence[1]) begin
          flags_next.microphone_bit = 1'b1;
          flags_next.button_bit     = 1'b1;
        end
      end else begin
        presence_next             = PRES_HEADSET;
        flags_next.headphone_bit  = 1'b1;
        flags_next.microphone_bit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_level  <= floor_rst;
      cand_level <= '0;
      run_count  <= '0;
      presence   <= PRES_NONE;
      out_valid  <= 1'b0;
    end else begin
      if (ctrl.restart) begin
        cal_level  <= restart_level;
        cand_level <= '0;
        run_count  <= '0;
      end else if (fire) begin
        cal_level  <= cal_level_next;
        cand_level <= cand_level_next;
        run_count  <= run_count_next;
        presence   <= presence_next;
      end
      if (item_ready) begin
        out_valid <= item_valid;
      end
    end
    if (fire) begin
      report_valid <= rv_next;
      flags        <= flags_next;
      level_now    <= cal_level_next;
    end
  end

endmodule

// File: src/headset_jack_classifier.sv
// Top level: configuration registers, front stage, request queue and back stage.
//
// Headset jack classifier. Takes one ADC reading per request and returns one result
// per request, in order. One request per clock is sustained while m_tready is high;
// the calibration and presence update in the back stage is combinational between
// its state registers, which sets that rate. Each request passes through the front
// register, the queue and the output register. Configuration writes restart
// calibration via a registered strobe; write them only while no request is in
// flight. The ADC reading sits in s_tdata, the conversion-error flag in s_tuser.
module headset_jack_classifier
  import hjc_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [SAMPLE_BITS-1:0] sample, zero padded
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,
  // [0] conv_error
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [0] headphone_bit, [1] microphone_bit, [2] button_bit, [3] fast_poll,
  // [SAMPLE_BITS+3:4] level_now, zero padded
  output logic [((SAMPLE_BITS+11)/8)*8-1:0]  m_tdata,
  // [0] report_valid
  output logic                               m_tuser,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int ITEM_W = 4 * SAMPLE_BITS + 12;
  localparam int OW     = ((SAMPLE_BITS + 11) / 8) * 8;

  typedef enum logic {
    REG_MANUAL = 1'b0,
    REG_FLOOR  = 1'b1
  } reg_idx_t;

  logic [SAMPLE_BITS-1:0] manual_level;
  logic [SAMPLE_BITS-1:0] auto_floor;
  logic                   restart;
  logic                   cfg_wr;
  reg_idx_t               reg_idx;
  hjc_ctrl_t              ctrl;
  logic [SAMPLE_BITS-1:0] restart_level;

  logic                   f_valid, f_ready;
  logic [ITEM_W-1:0]      f_item;
  logic                   q_valid, q_ready;
  logic [ITEM_W-1:0]      q_item;

  logic                   report_valid;
  hjc_flags_t             flags;
  logic [SAMPLE_BITS-1:0] level_now;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    case (reg_idx)
      REG_MANUAL: prdata = 32'(manual_level);
      REG_FLOOR:  prdata = 32'(auto_floor);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      manual_level <= '0;
      auto_floor   <= SAMPLE_BITS'(AUTO_FLOOR_RST);
      restart      <= 1'b0;
    end else begin
      restart <= cfg_wr;
      if (cfg_wr) begin
        case (reg_idx)
          REG_MANUAL: manual_level <= pwdata[SAMPLE_BITS-1:0];
          REG_FLOOR:  auto_floor   <= pwdata[SAMPLE_BITS-1:0];
          default:    ;
        endcase
      end
    end
  end

  assign restart_level    = (manual_level != '0) ? manual_level : auto_floor;
  assign ctrl.restart     = restart;
  assign ctrl.manual_zero = manual_level == '0;

  hjc_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ITEM_W      (ITEM_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .sample     (s_tdata[SAMPLE_BITS-1:0]),
    .conv_error (s_tuser),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  hjc_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_item)
  );

  hjc_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ITEM_W      (ITEM_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .restart_level (restart_level),
    .floor_rst     (SAMPLE_BITS'(AUTO_FLOOR_RST)),
    .item_valid    (q_valid),
    .item_ready    (q_ready),
    .item          (q_item),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .report_valid  (report_valid),
    .flags         (flags),
    .level_now     (level_now)
  );

  assign m_tuser = report_valid;
  assign m_tdata = OW'({level_now, flags.fast_poll, flags.button_bit,
                        flags.microphone_bit, flags.headphone_bit});

endmodule
